// File: rtl/core/sfcr_pkg.sv
// Shared types, constants and the CRC-8 byte step for the serial frame receiver.
`default_nettype none

package sfcr_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE   = 2'd2;

    // Register reset values
    localparam logic [7:0] RST_CRC_POLY   = 8'h07;
    localparam logic [7:0] RST_START_BYTE = 8'h01;
    localparam logic [7:0] RST_END_BYTE   = 8'h04;

    // Frame layout
    localparam logic [7:0] FRAME_LENGTH_CODE = 8'd16;
    localparam int unsigned PAYLOAD_BYTES    = 12;
    localparam int unsigned PAYLOAD_IDX_W    = 4;
    localparam int unsigned VALUE_W          = 24;

    // Byte position: count of frame bytes taken so far
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_HUNT          = 5'd0;
    localparam logic [POS_W-1:0] POS_CMD           = 5'd1;
    localparam logic [POS_W-1:0] POS_STATUS        = 5'd2;
    localparam logic [POS_W-1:0] POS_LENGTH        = 5'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD_FIRST = 5'd4;
    localparam logic [POS_W-1:0] POS_PAYLOAD_LAST  = 5'd15;
    localparam logic [POS_W-1:0] POS_CRC           = 5'd16;
    localparam logic [POS_W-1:0] POS_END           = 5'd17;

    typedef struct packed {
        logic [7:0] crc_polynomial;
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } sfcr_cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_four;
        logic [VALUE_W-1:0] value_three;
        logic [VALUE_W-1:0] value_two;
        logic [VALUE_W-1:0] value_one;
    } sfcr_result_t;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] sfcr_crc8_step(input logic [7:0] crc,
                                                  input logic [7:0] data,
                                                  input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/serial_frame_crc8_receiver_core.sv
// Top level: input register, frame tracker, result register and configuration registers.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[7:0]  = rx_byte
//   m_axis   out        tdata[95:0] = value_one, value_two, value_three, value_four
//   cfg      in         cfg_index selects register, cfg_data[7:0] is the value
//
// One byte per cycle is taken while the result register is not stalled. The
// end byte is first captured in the input register, where the frame check
// decides it; the result register then loads the result and drives m_axis.
// Reset is synchronous on aresetn and empties both registers and returns the
// tracker to hunting. A stalled result holds the result register, and the
// input register then fills once.
`default_nettype none

module serial_frame_crc8_receiver_core
    import sfcr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // rx_byte [7:0]
    input  wire logic [7:0]             s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // value_one [23:0], value_two [47:24], value_three [71:48], value_four [95:72]
    output logic [4*VALUE_W-1:0]        m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    sfcr_cfg_t    cfg_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    sfcr_result_t out_data_reg;

    logic         advance;
    logic         res_valid;
    sfcr_result_t res;

    // Move the input register forward whenever the result register is free
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_polynomial <= RST_CRC_POLY;
            cfg_reg.start_byte     <= RST_START_BYTE;
            cfg_reg.end_byte       <= RST_END_BYTE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CRC_POLY:   cfg_reg.crc_polynomial <= cfg_data;
                REG_START_BYTE: cfg_reg.start_byte     <= cfg_data;
                REG_END_BYTE:   cfg_reg.end_byte       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    sfcr_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (in_valid_reg && advance),
        .beat_byte  (in_byte_reg),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/sfcr_frame.sv
// Frame tracker: byte position, running CRC-8, payload store and result assembly.
`default_nettype none

module sfcr_frame
    import sfcr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         beat_valid,
    input  wire logic [7:0]   beat_byte,
    input  wire sfcr_cfg_t    cfg,
    output logic              res_valid,
    output sfcr_result_t      res
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic             match_reg, match_next;
    logic [7:0]       payload_reg [PAYLOAD_BYTES];

    logic [7:0]               crc_seed;
    logic [7:0]               crc_step;
    logic                     pl_we;
    logic [PAYLOAD_IDX_W-1:0] pl_idx;
    logic                     hit;

    // CRC over the current byte; a new frame starts from zero
    assign crc_seed = (pos_reg == POS_HUNT) ? 8'h00 : crc_reg;
    assign crc_step = sfcr_crc8_step(crc_seed, beat_byte, cfg.crc_polynomial);
    assign pl_idx   = PAYLOAD_IDX_W'(pos_reg - POS_PAYLOAD_FIRST);

    // Advance the frame position for one byte
    always_comb begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        match_next = match_reg;
        pl_we      = 1'b0;
        hit        = 1'b0;
        case (pos_reg) inside
            POS_HUNT: begin
                if (beat_byte == cfg.start_byte) begin
                    pos_next   = POS_CMD;
                    crc_next   = crc_step;
                    match_next = 1'b0;
                end else begin
                    pos_next   = POS_HUNT;
                    crc_next   = 8'h00;
                    match_next = 1'b0;
                end
            end
            POS_CMD, POS_STATUS: begin
                pos_next = pos_reg + 5'd1;
                crc_next = crc_step;
            end
            POS_LENGTH: begin
                if (beat_byte == FRAME_LENGTH_CODE) begin
                    pos_next = POS_PAYLOAD_FIRST;
                    crc_next = crc_step;
                end else begin
                    pos_next   = POS_HUNT;
                    crc_next   = 8'h00;
                    match_next = 1'b0;
                end
            end
            [POS_PAYLOAD_FIRST:POS_PAYLOAD_LAST]: begin
                pl_we    = 1'b1;
                pos_next = pos_reg + 5'd1;
                crc_next = crc_step;
            end
            POS_CRC: begin
                match_next = (beat_byte == crc_reg);
                pos_next   = POS_END;
            end
            POS_END: begin
                hit        = match_reg && (beat_byte == cfg.end_byte);
                pos_next   = POS_HUNT;
                crc_next   = 8'h00;
                match_next = 1'b0;
            end
            default: begin
                pos_next   = POS_HUNT;
                crc_next   = 8'h00;
                match_next = 1'b0;
            end
        endcase
    end

    // Hold tracker state between beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_HUNT;
            crc_reg   <= 8'h00;
            match_reg <= 1'b0;
        end else if (beat_valid) begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            match_reg <= match_next;
        end
    end

    // Store payload bytes
    always_ff @(posedge aclk) begin
        if (beat_valid && pl_we) begin
            payload_reg[pl_idx] <= beat_byte;
        end
    end

    // Assemble the little-endian values
    assign res_valid       = beat_valid && hit;
    assign res.value_one   = {payload_reg[2],  payload_reg[1],  payload_reg[0]};
    assign res.value_two   = {payload_reg[5],  payload_reg[4],  payload_reg[3]};
    assign res.value_three = {payload_reg[8],  payload_reg[7],  payload_reg[6]};
    assign res.value_four  = {payload_reg[11], payload_reg[10], payload_reg[9]};

endmodule

`default_nettype wire

// File: rtl/core/sfcr_checker.sv
// Port-level checker for the serial frame receiver, bound to the top level.
`default_nettype none

module sfcr_checker
    import sfcr_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [4*VALUE_W-1:0]   m_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready
);

    // A stalled result beat holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the result register
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Reset leaves the input side ready
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready after reset");

    // No result without an input beat in flight
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result appeared with no byte in flight");

endmodule

bind serial_frame_crc8_receiver_core sfcr_checker u_sfcr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
